/* rtl/core/utf8cp_pkg.sv */
// Shared types, byte class codes and helper functions of the UTF-8 code point decoder.
package utf8cp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpW      = 21;
  localparam int unsigned ClsW     = 3;
  localparam int unsigned HoldN    = 4;
  localparam int unsigned HoldIdxW = 2;
  localparam int unsigned CntW     = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QCntW    = 2;

  localparam logic [CpW-1:0] ReplacementCp = CpW'(32'h0000_FFFD);

  localparam logic [ClsW-1:0] ClsAscii = 3'd0;
  localparam logic [ClsW-1:0] ClsLead2 = 3'd1;
  localparam logic [ClsW-1:0] ClsLead3 = 3'd2;
  localparam logic [ClsW-1:0] ClsLead4 = 3'd3;
  localparam logic [ClsW-1:0] ClsCont  = 3'd4;
  localparam logic [ClsW-1:0] ClsBad   = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ClsW-1:0]  cls;
  } byte_t;

  typedef struct packed {
    byte_t chr;
    logic  final_flag;
  } item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           decode_error;
  } result_t;

  function automatic logic [ClsW-1:0] classify(input logic [ByteW-1:0] b);
    logic [ClsW-1:0] cls;
    if (b[7] == 1'b0) begin
      cls = ClsAscii;
    end else if (b[7:6] == 2'b10) begin
      cls = ClsCont;
    end else if (b[7:5] == 3'b110) begin
      cls = ClsLead2;
    end else if (b[7:4] == 4'b1110) begin
      cls = ClsLead3;
    end else if (b[7:3] == 5'b11110) begin
      cls = ClsLead4;
    end else begin
      cls = ClsBad;
    end
    return cls;
  endfunction

endpackage

/* rtl/core/utf8_codepoint_decoder.sv */
// Top level of the UTF-8 code point decoder.
// Bytes of a UTF-8 text enter one per transfer, with text_final_i set on the last byte, and
// leave as code points, with decode_error_o marking a U+FFFD replacement, run_end_o on the
// last code point caused by a byte and text_done_o on the last code point of the text.
// A two-entry input queue classifies bytes and lets the source run ahead while the decode
// engine works. The engine resolves one code point per cycle while the output register is
// free, and after a byte's code points it spends a further step closing that byte's run, in
// which it can take the next byte; this per-result loop of the engine sets the throughput.
// Overlong forms and surrogates pass.
module utf8_codepoint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        text_final_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [20:0] code_point_o,
  output logic        decode_error_o,
  output logic        run_end_o,
  output logic        text_done_o
);

  logic              q_valid;
  logic              q_ready;
  utf8cp_pkg::item_t q_item;

  utf8cp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .text_final_i (text_final_i),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_item_o     (q_item)
  );

  utf8cp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_item_i       (q_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .decode_error_o (decode_error_o),
    .run_end_o      (run_end_o),
    .text_done_o    (text_done_o)
  );

endmodule

/* rtl/core/utf8cp_front.sv */
// Input stage: classifies each incoming byte and queues it for the decoder.
module utf8cp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                text_byte_i,
  input  logic                      text_final_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output utf8cp_pkg::item_t         q_item_o
);

  utf8cp_pkg::item_t                    mem_q [utf8cp_pkg::QDepth];
  logic [utf8cp_pkg::QPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [utf8cp_pkg::QPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [utf8cp_pkg::QCntW-1:0]         cnt_q, cnt_d;
  logic                                 push, pop;
  utf8cp_pkg::item_t                    new_item;

  assign in_ready_o = (cnt_q != utf8cp_pkg::QCntW'(utf8cp_pkg::QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i & in_ready_o;
  assign pop  = q_valid_o & q_ready_i;

  always_comb begin
    new_item.chr.data   = text_byte_i;
    new_item.chr.cls    = utf8cp_pkg::classify(text_byte_i);
    new_item.final_flag = text_final_i;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/core/utf8cp_back.sv */
// Decode engine: holds undecided bytes, resolves one code point per cycle unless stalled, drives the output register.
module utf8cp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  output logic                     q_ready_o,
  input  utf8cp_pkg::item_t        q_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [20:0]              code_point_o,
  output logic                     decode_error_o,
  output logic                     run_end_o,
  output logic                     text_done_o
);

  utf8cp_pkg::byte_t                 buf_q [utf8cp_pkg::HoldN];
  utf8cp_pkg::byte_t                 buf_d [utf8cp_pkg::HoldN];
  logic [utf8cp_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                              fin_q, fin_d;
  logic                              busy_q, busy_d;
  logic                              prv_valid_q, prv_valid_d;
  utf8cp_pkg::result_t               prv_q, prv_d;
  logic                              out_valid_q, out_valid_d;
  utf8cp_pkg::result_t               out_q, out_d;
  logic                              out_run_end_q, out_run_end_d;
  logic                              out_done_q, out_done_d;

  logic                              has_emit, is_end, need_out, out_free, go, load;
  utf8cp_pkg::result_t               emit;
  logic [utf8cp_pkg::CntW-1:0]       consume_n;
  logic                              clear_all;
  logic [utf8cp_pkg::CntW-1:0]       need_n;
  logic                              conts_ok;
  logic [utf8cp_pkg::CntW-1:0]       cnt_base;
  logic [utf8cp_pkg::CpW-1:0]        joined;

  assign out_valid_o    = out_valid_q;
  assign code_point_o   = out_q.code_point;
  assign decode_error_o = out_q.decode_error;
  assign run_end_o      = out_run_end_q;
  assign text_done_o    = out_done_q;

  always_comb begin
    need_n   = 3'd1;
    conts_ok = 1'b0;
    joined   = '0;
    case (buf_q[0].cls)
      utf8cp_pkg::ClsLead2: begin
        need_n   = 3'd2;
        conts_ok = (buf_q[1].cls == utf8cp_pkg::ClsCont);
        joined   = utf8cp_pkg::CpW'({buf_q[0].data[4:0], buf_q[1].data[5:0]});
      end
      utf8cp_pkg::ClsLead3: begin
        need_n   = 3'd3;
        conts_ok = (buf_q[1].cls == utf8cp_pkg::ClsCont) &&
                   (buf_q[2].cls == utf8cp_pkg::ClsCont);
        joined   = utf8cp_pkg::CpW'({buf_q[0].data[3:0], buf_q[1].data[5:0],
                                     buf_q[2].data[5:0]});
      end
      utf8cp_pkg::ClsLead4: begin
        need_n   = 3'd4;
        conts_ok = (buf_q[1].cls == utf8cp_pkg::ClsCont) &&
                   (buf_q[2].cls == utf8cp_pkg::ClsCont) &&
                   (buf_q[3].cls == utf8cp_pkg::ClsCont);
        joined   = {buf_q[0].data[2:0], buf_q[1].data[5:0], buf_q[2].data[5:0],
                    buf_q[3].data[5:0]};
      end
      default: begin
        need_n   = 3'd1;
        conts_ok = 1'b0;
        joined   = '0;
      end
    endcase
  end

  always_comb begin
    has_emit          = 1'b0;
    is_end            = 1'b0;
    clear_all         = 1'b0;
    consume_n         = 3'd1;
    emit.code_point   = utf8cp_pkg::ReplacementCp;
    emit.decode_error = 1'b1;
    if (cnt_q == '0) begin
      is_end = 1'b1;
    end else if (buf_q[0].cls == utf8cp_pkg::ClsAscii) begin
      has_emit          = 1'b1;
      emit.code_point   = utf8cp_pkg::CpW'(buf_q[0].data);
      emit.decode_error = 1'b0;
    end else if (buf_q[0].cls == utf8cp_pkg::ClsCont || buf_q[0].cls == utf8cp_pkg::ClsBad) begin
      has_emit = 1'b1;
    end else if (cnt_q < need_n) begin
      if (fin_q) begin
        has_emit  = 1'b1;
        clear_all = 1'b1;
      end else begin
        is_end = 1'b1;
      end
    end else if (conts_ok) begin
      has_emit          = 1'b1;
      consume_n         = need_n;
      emit.code_point   = joined;
      emit.decode_error = 1'b0;
    end else begin
      has_emit = 1'b1;
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign need_out  = prv_valid_q && (has_emit || is_end);
  assign go        = busy_q && (!need_out || out_free);
  assign q_ready_o = !busy_q || (go && is_end);
  assign load      = q_valid_i && q_ready_o;
  assign cnt_base  = (busy_q && fin_q) ? '0 : cnt_q;

  always_comb begin
    for (int i = 0; i < utf8cp_pkg::HoldN; i++) begin
      buf_d[i] = buf_q[i];
    end
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    busy_d      = busy_q;
    prv_valid_d = prv_valid_q;
    prv_d       = prv_q;

    if (go && has_emit) begin
      prv_valid_d = 1'b1;
      prv_d       = emit;
      if (clear_all) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q - consume_n;
        for (int i = 0; i < utf8cp_pkg::HoldN; i++) begin
          if (i + int'(consume_n) < utf8cp_pkg::HoldN) begin
            buf_d[i] = buf_q[i + int'(consume_n)];
          end
        end
      end
    end

    if (go && is_end) begin
      prv_valid_d = 1'b0;
      busy_d      = 1'b0;
      if (fin_q) begin
        cnt_d = '0;
      end
    end

    if (load) begin
      buf_d[cnt_base[utf8cp_pkg::HoldIdxW-1:0]] = q_item_i.chr;
      cnt_d  = cnt_base + 1'b1;
      fin_d  = q_item_i.final_flag;
      busy_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    out_run_end_d = out_run_end_q;
    out_done_d    = out_done_q;
    if (go && need_out) begin
      out_valid_d   = 1'b1;
      out_d         = prv_q;
      out_run_end_d = is_end;
      out_done_d    = is_end && fin_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < utf8cp_pkg::HoldN; i++) begin
      buf_q[i] <= buf_d[i];
    end
    prv_q         <= prv_d;
    out_q         <= out_d;
    out_run_end_q <= out_run_end_d;
    out_done_q    <= out_done_d;
    fin_q         <= fin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      prv_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      prv_valid_q <= prv_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* test/utf8_codepoint_decoder_tb.sv */
// Self-checking testbench for the UTF-8 code point decoder, with a code point scoreboard.
module utf8_codepoint_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles = 10;
  localparam int unsigned ItemTarget  = 420;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned MaxPerByte  = 4;

  typedef struct packed {
    logic [utf8cp_pkg::CpW-1:0] cp;
    logic                       err;
    logic                       run_end;
    logic                       text_done;
  } cp_entry_t;

  class codepoint_scoreboard;
    cp_entry_t                    expected_cps[$];
    logic [utf8cp_pkg::ByteW-1:0] held[utf8cp_pkg::HoldN];
    int unsigned                  held_n;
    int unsigned                  fails;

    function new();
      held_n = 0;
      fails  = 0;
    endfunction

    function int unsigned pending();
      return expected_cps.size();
    endfunction

    function cp_entry_t make_cp(logic [utf8cp_pkg::CpW-1:0] cp, logic err);
      cp_entry_t e;
      e.cp        = cp;
      e.err       = err;
      e.run_end   = 1'b0;
      e.text_done = 1'b0;
      return e;
    endfunction

    function void drop_held(int unsigned n);
      for (int unsigned i = 0; i + n < held_n; i++) begin
        held[i] = held[i + n];
      end
      held_n = held_n - n;
    endfunction

    // Decodes the held bytes after one accepted transfer and queues what it yields.
    function void accept_byte(logic [utf8cp_pkg::ByteW-1:0] b, logic is_last);
      cp_entry_t                    step_cps[$];
      logic [utf8cp_pkg::ByteW-1:0] lead;
      logic [utf8cp_pkg::ByteW-1:0] c;
      logic [utf8cp_pkg::CpW-1:0]   cp;
      int unsigned                  extra;
      bit                           bad;
      bit                           ok;
      held[held_n] = b;
      held_n++;
      while (held_n > 0 && step_cps.size() < MaxPerByte) begin
        lead  = held[0];
        bad   = 1'b0;
        cp    = '0;
        extra = 0;
        casez (lead)
          8'b0???????: begin
            cp    = utf8cp_pkg::CpW'(lead);
            extra = 0;
          end
          8'b110?????: begin
            cp    = utf8cp_pkg::CpW'(lead[4:0]);
            extra = 1;
          end
          8'b1110????: begin
            cp    = utf8cp_pkg::CpW'(lead[3:0]);
            extra = 2;
          end
          8'b11110???: begin
            cp    = utf8cp_pkg::CpW'(lead[2:0]);
            extra = 3;
          end
          default: begin
            bad = 1'b1;
          end
        endcase
        if (bad) begin
          step_cps.insert(step_cps.size(), make_cp(utf8cp_pkg::ReplacementCp, 1'b1));
          drop_held(1);
          continue;
        end
        if (held_n < extra + 1) begin
          if (is_last) begin
            step_cps.insert(step_cps.size(), make_cp(utf8cp_pkg::ReplacementCp, 1'b1));
            held_n = 0;
          end
          break;
        end
        ok = 1'b1;
        for (int unsigned i = 1; i <= extra; i++) begin
          c = held[i];
          if (c[7:6] != 2'b10) begin
            ok = 1'b0;
            break;
          end
          cp = (cp << 6) | utf8cp_pkg::CpW'(c[5:0]);
        end
        if (ok) begin
          step_cps.insert(step_cps.size(), make_cp(cp, 1'b0));
          drop_held(extra + 1);
        end else begin
          step_cps.insert(step_cps.size(), make_cp(utf8cp_pkg::ReplacementCp, 1'b1));
          drop_held(1);
        end
      end
      if (is_last) begin
        held_n = 0;
      end
      if (step_cps.size() > 0) begin
        step_cps[step_cps.size() - 1].run_end   = 1'b1;
        step_cps[step_cps.size() - 1].text_done = is_last;
      end
      foreach (step_cps[i]) begin
        expected_cps.insert(expected_cps.size(), step_cps[i]);
      end
    endfunction

    function void check_code_point(logic [utf8cp_pkg::CpW-1:0] cp, logic err, logic run_end,
                                   logic text_done);
      cp_entry_t exp_e;
      if (expected_cps.size() == 0) begin
        $error("code point %h transferred with none expected", cp);
        fails++;
        return;
      end
      exp_e = expected_cps.pop_front();
      if (cp !== exp_e.cp) begin
        $error("code_point: expected %h, got %h", exp_e.cp, cp);
        fails++;
      end
      if (err !== exp_e.err) begin
        $error("decode_error: expected %b, got %b", exp_e.err, err);
        fails++;
      end
      if (run_end !== exp_e.run_end) begin
        $error("run_end: expected %b, got %b", exp_e.run_end, run_end);
        fails++;
      end
      if (text_done !== exp_e.text_done) begin
        $error("text_done: expected %b, got %b", exp_e.text_done, text_done);
        fails++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        text_final_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [20:0] code_point_o;
  logic        decode_error_o;
  logic        run_end_o;
  logic        text_done_o;

  codepoint_scoreboard sb = new();

  int unsigned                  cycles = 0;
  int unsigned                  n_sent = 0;
  bit                           no_idle = 1'b0;
  bit                           hold_req = 1'b0;
  logic [utf8cp_pkg::ByteW-1:0] text_bytes[$];

  // Final flag in bit 8, byte in bits 7:0.
  logic [8:0] directed_items[$] = '{
    9'h000, 9'h07F, 9'h0C3, 9'h0A9, 9'h0EF, 9'h0BF, 9'h0BD, 9'h0F7, 9'h0BF, 9'h0BF,
    9'h0BF, 9'h080, 9'h0FF, 9'h0F8, 9'h0E2, 9'h041, 9'h0F0, 9'h041, 9'h042, 9'h043,
    9'h0F0, 9'h19F, 9'h10A
  };

  utf8_codepoint_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .text_final_i   (text_final_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .code_point_o   (code_point_o),
    .decode_error_o (decode_error_o),
    .run_end_o      (run_end_o),
    .text_done_o    (text_done_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_byte(logic [utf8cp_pkg::ByteW-1:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function automatic void add_lead(int unsigned len);
    case (len)
      1: add_byte({1'b0, 7'($urandom)});
      2: add_byte({3'b110, 5'($urandom)});
      3: add_byte({4'b1110, 4'($urandom)});
      default: add_byte({5'b11110, 3'($urandom)});
    endcase
  endfunction

  function automatic void add_conts(int unsigned n);
    repeat (n) add_byte({2'b10, 6'($urandom)});
  endfunction

  function automatic void build_text();
    int unsigned len;
    int unsigned n_cps;
    text_bytes.delete();
    n_cps = $urandom_range(1, 10);
    repeat (n_cps) begin
      len = $urandom_range(1, 4);
      if ($urandom_range(0, 99) < 75) begin
        add_lead(len);
        add_conts(len - 1);
      end else begin
        case ($urandom_range(0, 2))
          0: add_byte(8'($urandom_range(0, 255)));
          1: add_conts(1);
          default: begin
            len = $urandom_range(2, 4);
            add_lead(len);
            add_conts($urandom_range(0, len - 2));
            len = $urandom_range(1, 4);
            add_lead(len);
            add_conts(len - 1);
          end
        endcase
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      len = $urandom_range(2, 4);
      add_lead(len);
      add_conts($urandom_range(0, len - 2));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    text_byte_i  = b;
    text_final_i = is_last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_byte(b, is_last);
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles++;
      if (out_valid_o && out_ready_i) begin
        sb.check_code_point(code_point_o, decode_error_o, run_end_o, text_done_o);
      end
      if (cycles > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned stage;
    stage        = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    text_byte_i  = '0;
    text_final_i = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_items[i]) begin
      send_byte(directed_items[i][7:0], directed_items[i][8]);
    end

    while (n_sent < ItemTarget) begin
      build_text();
      foreach (text_bytes[i]) begin
        send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
      if (stage == 0 && n_sent >= 100) begin
        no_idle = 1'b1;
        stage   = 1;
      end else if (stage == 1 && n_sent >= 170) begin
        no_idle = 1'b0;
        stage   = 2;
      end else if (stage == 2 && n_sent >= 220) begin
        // The receiver stalls while bytes keep coming, so the input side must back up.
        no_idle  = 1'b1;
        hold_req = 1'b1;
        stage    = 3;
      end else if (stage == 3 && n_sent >= 270) begin
        no_idle = 1'b0;
        wait_drained();
        stage = 4;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
